FILE: rtl/i2c_bit_bang_master_top_macros.svh
// Assertion macros for the I2C bit-bang master top level.
`ifndef I2C_BIT_BANG_MASTER_TOP_MACROS_SVH
`define I2C_BIT_BANG_MASTER_TOP_MACROS_SVH

// Condition implies consequence in the same cycle.
`define I2CBB_ASSERT_IMPL(label, clk_s, rst_n_s, cond, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (cond) |-> (cons)) \
		else $error("i2c bit-bang master: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define I2CBB_ASSERT_NEXT(label, clk_s, rst_n_s, cond, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (cond) |=> (cons)) \
		else $error("i2c bit-bang master: next-cycle check failed");

`endif

FILE: rtl/i2cbb_pkg.sv
package i2cbb_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_SACK  = 3'd5,
		CMD_RACK  = 3'd6
	} cmd_t;

	localparam logic [15:0] STEP_TICKS_RESET = 16'd720;
	localparam logic [7:0]  MSB_MASK         = 8'h80;
	localparam logic [2:0]  REG_STEP_TICKS   = 3'd0;

	// One input beat, unpacked from tdata.
	typedef struct packed {
		logic       sda_in;
		logic       ack_level;
		logic [7:0] byte_in;
		logic [2:0] action;
	} item_t;

	// One result beat, in tdata order from the top bit down.
	typedef struct packed {
		logic       ack_seen;
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
		logic       sda_out;
		logic       scl_out;
	} res_t;

	function automatic logic [4:0] seq_len(input cmd_t cmd);
		logic [4:0] len;
		case (cmd)
			CMD_START: len = 5'd4;
			CMD_STOP:  len = 5'd3;
			CMD_WRITE: len = 5'd24;
			CMD_READ:  len = 5'd25;
			CMD_SACK:  len = 5'd3;
			CMD_RACK:  len = 5'd4;
			default:   len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

FILE: rtl/i2c_bit_bang_master_top.sv
// I2C bit-bang master: one input beat per clock tick of the pin sequencer, one result beat each.
// Each input beat goes through the input register, then the result register, and waits in the
// input register while the result side stalls. The only state loop is the sequencer update.
// Throughput: one beat per cycle as long as the result side keeps taking beats.
// Reset (arst_n low, asynchronous): pins released, sequencer idle, step_ticks back to 720,
// both pipeline stages empty.
module i2c_bit_bang_master_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream. tdata: action[2:0], byte_in[10:3], ack_level[11], sda_in[12], zero[15:13].
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	// Result stream. tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3],
	// read_data[11:4], ack_seen[12], zero[15:13].
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,
	// Register port; step_ticks lies at byte address 0.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]       step_ticks_q;
	logic              s1_valid;
	i2cbb_pkg::item_t  item_s1;
	logic              out_valid_s2;
	i2cbb_pkg::res_t   res_s2;
	i2cbb_pkg::res_t   res_next;
	logic              advance;

	// Configuration register. The port never stalls.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q <= i2cbb_pkg::STEP_TICKS_RESET;
		end else if (psel && penable && pwrite && (paddr == i2cbb_pkg::REG_STEP_TICKS)) begin
			step_ticks_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr == i2cbb_pkg::REG_STEP_TICKS) ? {16'd0, step_ticks_q} : 32'd0;

	// The input register feeds the sequencer. A beat leaves stage one when the result
	// register is empty or being emptied in the same cycle, so stage one accepts a new
	// beat every cycle as long as the result side keeps taking beats.
	assign advance       = s1_valid && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= i2cbb_pkg::item_t'(s_axis_tdata[12:0]);
		end
	end

	// The sequencer state moves only when a beat goes from stage one to the result register,
	// so each input beat is exactly one tick of the pin sequence.
	i2cbb_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.step_ticks (step_ticks_q),
		.item       (item_s1),
		.res        (res_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {3'd0, res_s2};

`include "i2c_bit_bang_master_top_macros.svh"

	// A beat that moves on always lands in the result register.
	`I2CBB_ASSERT_NEXT(a_advance_fills_out, clk, arst_n, advance, m_axis_tvalid)
	// An accepted input beat always occupies stage one afterwards.
	`I2CBB_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_axis_tvalid && s_axis_tready, s1_valid)
	// The finishing tick already reports the sequencer as idle.
	`I2CBB_ASSERT_IMPL(a_done_not_busy, clk, arst_n, m_axis_tvalid && m_axis_tdata[3],
		!m_axis_tdata[2])

endmodule

FILE: rtl/i2cbb_seq.sv
module i2cbb_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [15:0]       step_ticks,
	input  i2cbb_pkg::item_t  item,
	output i2cbb_pkg::res_t   res
);

	i2cbb_pkg::cmd_t cmd_q, cmd_n, cmd_w;
	logic [4:0]  step_q, step_n, step_w;
	logic [15:0] tick_q, tick_n, tick_w, tick_inc, limit;
	logic [7:0]  shift_q, shift_n, shift_w;
	logic [7:0]  rxb_q, rxb_n;
	logic        rack_q, rack_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        launch, first_tick, done;
	logic [4:0]  rel, step_inc;
	logic [8:0]  prod;
	logic [3:0]  quo;
	logic [4:0]  rem;
	logic [7:0]  bit_mask;

	assign launch = (cmd_q == i2cbb_pkg::CMD_IDLE) &&
		(item.action >= i2cbb_pkg::CMD_START) && (item.action <= i2cbb_pkg::CMD_RACK);
	assign cmd_w   = launch ? i2cbb_pkg::cmd_t'(item.action) : cmd_q;
	assign step_w  = launch ? 5'd0 : step_q;
	assign tick_w  = launch ? 16'd0 : tick_q;
	assign limit   = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
	assign first_tick = (cmd_w != i2cbb_pkg::CMD_IDLE) && (tick_w == 16'd0);

	always_comb begin
		shift_w = 8'd0;
		if (!launch) begin
			shift_w = shift_q;
		end else if (item.action == i2cbb_pkg::CMD_WRITE) begin
			shift_w = item.byte_in;
		end else if (item.action == i2cbb_pkg::CMD_SACK) begin
			shift_w = {7'd0, item.ack_level};
		end
	end

	// Split the step into bit and phase; x/3 is (11x)>>5 for x below 32.
	assign rel  = (cmd_w == i2cbb_pkg::CMD_READ) ? (step_w - 5'd1) : step_w;
	assign prod = {4'd0, rel} * 9'd11;
	assign quo  = prod[8:5];
	assign rem  = rel - ({1'b0, quo} * 5'd3);
	assign bit_mask = i2cbb_pkg::MSB_MASK >> quo[2:0];

	// Pin actions and sampling on the first tick of a step.
	always_comb begin
		scl_n   = scl_q;
		sda_n   = sda_q;
		shift_n = shift_w;
		rack_n  = rack_q;
		if (first_tick) begin
			case (cmd_w)
				i2cbb_pkg::CMD_START: begin
					case (step_w)
						5'd0:    sda_n = 1'b1;
						5'd1:    scl_n = 1'b1;
						5'd2:    sda_n = 1'b0;
						default: scl_n = 1'b0;
					endcase
				end
				i2cbb_pkg::CMD_STOP: begin
					case (step_w)
						5'd0:    sda_n = 1'b0;
						5'd1:    scl_n = 1'b1;
						default: sda_n = 1'b1;
					endcase
				end
				i2cbb_pkg::CMD_WRITE: begin
					case (rem[1:0])
						2'd0:    sda_n = |(shift_w & bit_mask);
						2'd1:    scl_n = 1'b1;
						default: scl_n = 1'b0;
					endcase
				end
				i2cbb_pkg::CMD_READ: begin
					if (step_w == 5'd0) begin
						sda_n = 1'b1;
					end else begin
						case (rem[1:0])
							2'd0:    scl_n = 1'b1;
							2'd1:    if (item.sda_in) shift_n = shift_w | bit_mask;
							default: scl_n = 1'b0;
						endcase
					end
				end
				i2cbb_pkg::CMD_SACK: begin
					case (step_w)
						5'd0:    sda_n = shift_w[0];
						5'd1:    scl_n = 1'b1;
						default: scl_n = 1'b0;
					endcase
				end
				i2cbb_pkg::CMD_RACK: begin
					case (step_w)
						5'd0:    sda_n = 1'b1;
						5'd1:    scl_n = 1'b1;
						5'd2:    rack_n = item.sda_in;
						default: scl_n = 1'b0;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign tick_inc = tick_w + 16'd1;
	assign step_inc = step_w + 5'd1;

	// Next command, step and tick count.
	always_comb begin
		cmd_n  = cmd_w;
		step_n = step_w;
		tick_n = tick_w;
		rxb_n  = rxb_q;
		done   = 1'b0;
		if (cmd_w != i2cbb_pkg::CMD_IDLE) begin
			tick_n = tick_inc;
			if (tick_inc >= limit) begin
				tick_n = 16'd0;
				step_n = step_inc;
				if (step_inc >= i2cbb_pkg::seq_len(cmd_w)) begin
					if (cmd_w == i2cbb_pkg::CMD_READ) rxb_n = shift_n;
					cmd_n  = i2cbb_pkg::CMD_IDLE;
					step_n = 5'd0;
					done   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cbb_pkg::CMD_IDLE;
			step_q  <= 5'd0;
			tick_q  <= 16'd0;
			shift_q <= 8'd0;
			rxb_q   <= 8'd0;
			rack_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (en) begin
			cmd_q   <= cmd_n;
			step_q  <= step_n;
			tick_q  <= tick_n;
			shift_q <= shift_n;
			rxb_q   <= rxb_n;
			rack_q  <= rack_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
		end
	end

	always_comb begin
		res.scl_out   = scl_n;
		res.sda_out   = sda_n;
		res.busy_res  = (cmd_n != i2cbb_pkg::CMD_IDLE);
		res.done_res  = done;
		res.read_data = rxb_n;
		res.ack_seen  = rack_n;
	end

endmodule

FILE: tb/sv/tb_i2c_bit_bang_master_top.sv
module tb_i2c_bit_bang_master_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Action code that the block treats as a plain tick.
	localparam logic [2:0] ACT_PLAIN_TICK = 3'd7;
	// Byte address of the step_ticks register.
	localparam logic [2:0] STEP_ADDR = 3'(4 * i2cbb_pkg::REG_STEP_TICKS);
	// Cycles without any accepted beat before the run is declared hung. The
	// longest correct quiet stretch is the receiver's long hold-off plus a
	// register update, both far below this.
	localparam int STALL_LIMIT = 2000;
	// Length of the one long receiver hold-off, and the beat count where it starts.
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AT_BEAT = 400;

	// Tracks the pin sequencer beat by beat and keeps the pin and status
	// values that each accepted input beat must produce, oldest first.
	class i2c_pin_scoreboard;
		logic [15:0]       step_ticks;
		logic              scl_lvl;
		logic              sda_lvl;
		i2cbb_pkg::cmd_t   cmd;
		logic [4:0]        step_idx;
		logic [7:0]        shift_reg;
		logic [7:0]        rx_byte;
		logic              rx_ack;
		logic [15:0]       tick_cnt;
		i2cbb_pkg::res_t   expected_pins[$];
		int                failures;
		int                checked;

		function new();
			step_ticks = i2cbb_pkg::STEP_TICKS_RESET;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			cmd = i2cbb_pkg::CMD_IDLE;
			step_idx = '0;
			shift_reg = '0;
			rx_byte = '0;
			rx_ack = 1'b0;
			tick_cnt = '0;
			failures = 0;
			checked = 0;
		endfunction

		function void set_step_ticks(logic [15:0] ticks);
			step_ticks = ticks;
		endfunction

		function bit busy();
			return cmd != i2cbb_pkg::CMD_IDLE;
		endfunction

		function int pending();
			return expected_pins.size();
		endfunction

		function void note_failure(string what);
			failures++;
			if (failures <= 10) begin
				$display("MISMATCH: %s", what);
			end
		endfunction

		function int steps_in(i2cbb_pkg::cmd_t c);
			case (c)
				i2cbb_pkg::CMD_START: return 4;
				i2cbb_pkg::CMD_STOP:  return 3;
				i2cbb_pkg::CMD_WRITE: return 24;
				i2cbb_pkg::CMD_READ:  return 25;
				i2cbb_pkg::CMD_SACK:  return 3;
				i2cbb_pkg::CMD_RACK:  return 4;
				default:              return 0;
			endcase
		endfunction

		// Pin action or SDA sample of the current step, done on its first tick.
		function void apply_step(logic sda_pin);
			int s;
			int bit_no;
			int phase;
			s = step_idx;
			case (cmd)
				i2cbb_pkg::CMD_START: begin
					case (s)
						0:       sda_lvl = 1'b1;
						1:       scl_lvl = 1'b1;
						2:       sda_lvl = 1'b0;
						default: scl_lvl = 1'b0;
					endcase
				end
				i2cbb_pkg::CMD_STOP: begin
					case (s)
						0:       sda_lvl = 1'b0;
						1:       scl_lvl = 1'b1;
						default: sda_lvl = 1'b1;
					endcase
				end
				i2cbb_pkg::CMD_WRITE: begin
					bit_no = (s / 3) % 8;
					phase = s % 3;
					if (phase == 0)
						sda_lvl = (shift_reg & (i2cbb_pkg::MSB_MASK >> bit_no)) != 8'd0;
					else if (phase == 1) scl_lvl = 1'b1;
					else scl_lvl = 1'b0;
				end
				i2cbb_pkg::CMD_READ: begin
					if (s == 0) begin
						sda_lvl = 1'b1;
					end else begin
						bit_no = ((s - 1) / 3) % 8;
						phase = (s - 1) % 3;
						if (phase == 0) scl_lvl = 1'b1;
						else if (phase == 1) begin
							if (sda_pin) shift_reg = shift_reg | (i2cbb_pkg::MSB_MASK >> bit_no);
						end else scl_lvl = 1'b0;
					end
				end
				i2cbb_pkg::CMD_SACK: begin
					case (s)
						0:       sda_lvl = shift_reg[0];
						1:       scl_lvl = 1'b1;
						default: scl_lvl = 1'b0;
					endcase
				end
				i2cbb_pkg::CMD_RACK: begin
					case (s)
						0:       sda_lvl = 1'b1;
						1:       scl_lvl = 1'b1;
						2:       rx_ack = sda_pin;
						default: scl_lvl = 1'b0;
					endcase
				end
				default: ;
			endcase
		endfunction

		// Advances the sequencer by one accepted beat and queues its result.
		function void note_beat(i2cbb_pkg::item_t it);
			logic [15:0]     limit;
			logic            done;
			i2cbb_pkg::res_t r;
			limit = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
			done = 1'b0;
			if (cmd == i2cbb_pkg::CMD_IDLE && it.action >= i2cbb_pkg::CMD_START
					&& it.action <= i2cbb_pkg::CMD_RACK) begin
				cmd = i2cbb_pkg::cmd_t'(it.action);
				step_idx = '0;
				tick_cnt = '0;
				if (cmd == i2cbb_pkg::CMD_WRITE) shift_reg = it.byte_in;
				else if (cmd == i2cbb_pkg::CMD_SACK) shift_reg = {7'd0, it.ack_level};
				else shift_reg = '0;
			end
			if (cmd != i2cbb_pkg::CMD_IDLE) begin
				if (tick_cnt == 16'd0) apply_step(it.sda_in);
				tick_cnt = tick_cnt + 16'd1;
				if (tick_cnt >= limit) begin
					tick_cnt = '0;
					step_idx = step_idx + 5'd1;
					if (step_idx >= steps_in(cmd)) begin
						if (cmd == i2cbb_pkg::CMD_READ) rx_byte = shift_reg;
						cmd = i2cbb_pkg::CMD_IDLE;
						step_idx = '0;
						done = 1'b1;
					end
				end
			end
			r.scl_out = scl_lvl;
			r.sda_out = sda_lvl;
			r.busy_res = (cmd != i2cbb_pkg::CMD_IDLE);
			r.done_res = done;
			r.read_data = rx_byte;
			r.ack_seen = rx_ack;
			expected_pins.push_back(r);
		endfunction

		function void check_beat(i2cbb_pkg::res_t got);
			i2cbb_pkg::res_t want;
			bit              same;
			checked++;
			if (expected_pins.size() == 0) begin
				note_failure($sformatf("result beat %0d arrived with nothing expected", checked));
				return;
			end
			want = expected_pins.pop_front();
			same = (got.scl_out === want.scl_out) && (got.sda_out === want.sda_out)
				&& (got.busy_res === want.busy_res) && (got.done_res === want.done_res)
				&& (got.read_data === want.read_data) && (got.ack_seen === want.ack_seen);
			if (!same) begin
				note_failure($sformatf(
					{"beat %0d expected scl=%b sda=%b busy=%b done=%b data=%h ack=%b, ",
					"got scl=%b sda=%b busy=%b done=%b data=%h ack=%b"},
					checked, want.scl_out, want.sda_out, want.busy_res, want.done_res,
					want.read_data, want.ack_seen, got.scl_out, got.sda_out, got.busy_res,
					got.done_res, got.read_data, got.ack_seen));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Idle insertion switches for the sender and the receiver, set per phase.
	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;

	i2c_pin_scoreboard pins_board;

	always #2 clk = ~clk;

	i2c_bit_bang_master_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Offers one input beat, optionally after a random gap, and returns at the
	// edge where it is taken. tvalid is left high so that a back-to-back beat
	// does not need to lower and raise it within one time step.
	task automatic send_beat(input i2cbb_pkg::item_t it);
		int gap;
		gap = src_gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, it};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pins_board.note_beat(it);
	endtask

	function automatic logic pick_sda(input int sda_mode);
		return (sda_mode == 2) ? logic'($urandom_range(0, 1)) : logic'(sda_mode);
	endfunction

	// Issues one action, then plain ticks until the sequencer is idle again.
	// A stray action, if any, goes out on the second beat while the block is
	// still busy, so it must be ignored.
	task automatic run_command(input logic [2:0] act, input logic [7:0] data,
			input logic ack, input int sda_mode, input logic [2:0] stray);
		i2cbb_pkg::item_t it;
		int               n;
		it.action = act;
		it.byte_in = data;
		it.ack_level = ack;
		it.sda_in = pick_sda(sda_mode);
		send_beat(it);
		n = 0;
		while (pins_board.busy()) begin
			n++;
			it.action = (n == 1) ? stray : i2cbb_pkg::CMD_IDLE;
			it.byte_in = 8'($urandom_range(0, 255));
			it.ack_level = 1'($urandom_range(0, 1));
			it.sda_in = pick_sda(sda_mode);
			send_beat(it);
		end
	endtask

	// Mostly complete command sequences with random content; commands issued
	// while busy, the spare action code and idle ticks make up the noise.
	task automatic random_phase(input int beats);
		i2cbb_pkg::item_t it;
		for (int n = 0; n < beats; n++) begin
			it.byte_in = 8'($urandom_range(0, 255));
			it.ack_level = 1'($urandom_range(0, 1));
			it.sda_in = 1'($urandom_range(0, 1));
			if (!pins_board.busy() && $urandom_range(0, 9) < 7) begin
				it.action = 3'($urandom_range(i2cbb_pkg::CMD_START, i2cbb_pkg::CMD_RACK));
			end else if ($urandom_range(0, 15) == 0) begin
				it.action = 3'($urandom_range(i2cbb_pkg::CMD_START, ACT_PLAIN_TICK));
			end else begin
				it.action = ($urandom_range(0, 19) == 0) ? ACT_PLAIN_TICK : i2cbb_pkg::CMD_IDLE;
			end
			send_beat(it);
		end
	endtask

	// Stops offering beats and waits for every expected result to leave the
	// two-stage pipeline, then idles before returning.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pins_board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register transfers take a setup and an access phase; the task then idles
	// with psel low so the next transfer never touches psel in the same step.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_step_ticks(input logic [15:0] want);
		logic [31:0] rd;
		apb_read(STEP_ADDR, rd);
		if (rd[15:0] !== want) begin
			pins_board.note_failure($sformatf("step_ticks read back expected %0d, got %0d",
				want, rd[15:0]));
		end
	endtask

	// The sequencer may still be in the middle of a step here; the new value
	// applies from the next beat on in both the block and the scoreboard.
	task automatic program_step_ticks(input logic [15:0] ticks);
		drain_results();
		apb_write(STEP_ADDR, {16'd0, ticks});
		pins_board.set_step_ticks(ticks);
		check_step_ticks(ticks);
	endtask

	// Result side: random tready gaps, plus one long hold-off while the sender
	// keeps offering, so the pipeline fills and backpressures the input.
	initial begin : result_sink
		int gap;
		int taken;
		bit held;
		taken = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = sink_gaps ? $urandom_range(0, 7) : 0;
			if (!held && taken == HOLD_AT_BEAT) begin
				gap = HOLD_CYCLES;
				held = 1'b1;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			pins_board.check_beat(i2cbb_pkg::res_t'(m_axis_tdata[12:0]));
			taken++;
		end
	end

	// Ends the run if neither stream moves for too long.
	initial begin : stall_watch
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int               phase_ticks[6];
		i2cbb_pkg::item_t first_it;
		pins_board = new();
		phase_ticks = '{1, 3, 0, 2, 4, 1};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register must come out of reset at its default.
		check_step_ticks(i2cbb_pkg::STEP_TICKS_RESET);

		// At the default rate a start only gets through its first step here.
		first_it.action = i2cbb_pkg::CMD_START;
		first_it.byte_in = 8'h00;
		first_it.ack_level = 1'b0;
		first_it.sda_in = pick_sda(2);
		send_beat(first_it);
		for (int n = 0; n < 30; n++) begin
			random_phase(1);
		end

		// At the largest rate the step keeps counting; switching to zero then
		// ends the step at once, since its elapsed ticks already exceed one.
		program_step_ticks(16'hFFFF);
		random_phase(30);
		program_step_ticks(16'd0);

		// Directed commands at one tick per step: finish the pending start,
		// write both extreme bytes, sample both ack levels, read all-ones,
		// all-zeros and mixed bytes, send ack and nack, stop, then the spare
		// action code and a plain tick while idle. Two commands carry a stray
		// command issued while the block is still busy.
		run_command(i2cbb_pkg::CMD_IDLE, 8'h00, 1'b0, 2, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_START, 8'h5A, 1'b1, 2, i2cbb_pkg::CMD_STOP);
		run_command(i2cbb_pkg::CMD_WRITE, 8'h00, 1'b1, 2, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_WRITE, 8'hFF, 1'b0, 2, i2cbb_pkg::CMD_READ);
		run_command(i2cbb_pkg::CMD_RACK, 8'h00, 1'b0, 0, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_RACK, 8'hFF, 1'b1, 1, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_READ, 8'h00, 1'b0, 1, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_READ, 8'hFF, 1'b1, 0, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_READ, 8'hA5, 1'b0, 2, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_SACK, 8'hFF, 1'b0, 2, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_SACK, 8'h00, 1'b1, 2, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_STOP, 8'h3C, 1'b0, 2, i2cbb_pkg::CMD_IDLE);
		run_command(ACT_PLAIN_TICK, 8'hFF, 1'b1, 1, i2cbb_pkg::CMD_IDLE);
		run_command(i2cbb_pkg::CMD_IDLE, 8'h00, 1'b0, 0, i2cbb_pkg::CMD_IDLE);

		// Random phases over several rates, with idling on either side turned
		// on and off so that some stretches run at full rate.
		for (int p = 0; p < 6; p++) begin
			program_step_ticks(16'(phase_ticks[p]));
			src_gaps = (p % 2 == 0);
			sink_gaps = (p % 3 != 2);
			random_phase(205);
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (pins_board.failures == 0 && pins_board.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
